// ===== sv/u16550_pkg.sv =====
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types and constants of the 16550 register model.
// ----------------------------------------------------------------------------
package u16550_pkg;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RX_CHAR = 2'd2,
        OP_IRQ     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_SIZE   = 2'd1,
        ST_MISALIGNED = 2'd2,
        ST_RX_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_RBR_THR = 3'd0,
        REG_IER     = 3'd1,
        REG_IIR_FCR = 3'd2,
        REG_LCR     = 3'd3,
        REG_MCR     = 3'd4,
        REG_LSR     = 3'd5,
        REG_MSR     = 3'd6,
        REG_SCR     = 3'd7
    } reg_sel_t;

    // configuration register indexes
    localparam logic CFG_BASE_ADDRESS = 1'b0;
    localparam logic CFG_STRIDE       = 1'b1;

    localparam logic [7:0] LCR_DIV_LATCH = 8'h80;
    localparam logic [7:0] LSR_DR        = 8'h01;
    localparam logic [7:0] LSR_RESET     = 8'h60;
    localparam logic [7:0] IER_RX        = 8'h01;
    localparam logic [7:0] IER_TX        = 8'h02;
    localparam logic [7:0] IIR_NONE      = 8'h01;
    localparam logic [7:0] IIR_THRE      = 8'h02;
    localparam logic [7:0] IIR_RDA       = 8'h04;

    typedef struct packed {
        op_t         op;
        logic [63:0] address;
        logic [3:0]  size_bytes;
        logic [7:0]  write_data;
        logic [7:0]  rx_char;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_rise;
    } result_t;

endpackage

// ===== sv/u16550_in_stage.sv =====
// ----------------------------------------------------------------------------
// u16550_in_stage
// Input register: holds one transaction until the execute stage takes it.
// ----------------------------------------------------------------------------
module u16550_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  u16550_pkg::item_t  in_item,
    input  logic               take,       // downstream can accept this cycle
    output logic               fire,       // held item executes this cycle
    output u16550_pkg::item_t  item
);
    import u16550_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign fire     = valid_reg && take;
    assign in_ready = !valid_reg || take;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/u16550_core.sv =====
// ----------------------------------------------------------------------------
// u16550_core
// Register file, bus decode and receive/interrupt logic.
// ----------------------------------------------------------------------------
module u16550_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  u16550_pkg::item_t   item,
    input  logic [63:0]         base_address,
    input  logic                stride_is_eight,
    output u16550_pkg::result_t result
);
    import u16550_pkg::*;

    logic [7:0] rbr_reg, rbr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic [7:0] ier_reg, ier_next;
    logic [7:0] fcr_reg, fcr_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] scr_reg, scr_next;
    logic       dr_reg, dr_next;
    logic       prev_irq_reg, prev_irq_next;

    logic       size_ok;
    logic       misaligned;
    logic [5:0] offset;
    reg_sel_t   sel;
    logic       dlab;
    logic [7:0] lsr;
    logic [7:0] iir;
    logic       irq;

    // only the low offset bits reach the register number
    assign offset = item.address[5:0] - base_address[5:0];
    assign sel    = reg_sel_t'(stride_is_eight ? offset[5:3] : offset[4:2]);
    assign dlab   = (lcr_reg & LCR_DIV_LATCH) != 8'h00;
    assign lsr    = LSR_RESET | (dr_reg ? LSR_DR : 8'h00);

    assign size_ok = (item.size_bytes == 4'd1) || (item.size_bytes == 4'd2) ||
                     (item.size_bytes == 4'd4) ||
                     ((item.size_bytes == 4'd8) && stride_is_eight);
    assign misaligned = stride_is_eight ? (item.address[2:0] != 3'd0)
                                        : (item.address[1:0] != 2'd0);

    always_comb
    begin
        priority if (((ier_reg & IER_RX) != 8'h00) && dr_reg)
        begin
            iir = IIR_RDA;
        end
        else if ((ier_reg & IER_TX) != 8'h00)
        begin
            iir = IIR_THRE;
        end
        else
        begin
            iir = IIR_NONE;
        end
    end

    assign irq = (iir & IIR_NONE) == 8'h00;

    always_comb
    begin
        rbr_next      = rbr_reg;
        dll_next      = dll_reg;
        dlm_next      = dlm_reg;
        ier_next      = ier_reg;
        fcr_next      = fcr_reg;
        lcr_next      = lcr_reg;
        mcr_next      = mcr_reg;
        scr_next      = scr_reg;
        dr_next       = dr_reg;
        prev_irq_next = prev_irq_reg;
        result        = '0;

        unique case (item.op)
            OP_READ, OP_WRITE:
            begin
                priority if (!size_ok)
                begin
                    result.status = ST_BAD_SIZE;
                end
                else if (misaligned)
                begin
                    result.status = ST_MISALIGNED;
                end
                else if (item.op == OP_READ)
                begin
                    unique case (sel)
                        REG_RBR_THR:
                        begin
                            if (dlab)
                            begin
                                result.read_data = dll_reg;
                            end
                            else
                            begin
                                result.read_data = rbr_reg;
                                dr_next          = 1'b0;
                            end
                        end
                        REG_IER:     result.read_data = dlab ? dlm_reg : ier_reg;
                        REG_IIR_FCR: result.read_data = iir;
                        REG_LCR:     result.read_data = lcr_reg;
                        REG_MCR:     result.read_data = mcr_reg;
                        REG_LSR:     result.read_data = lsr;
                        REG_MSR:     result.read_data = 8'h00;
                        REG_SCR:     result.read_data = scr_reg;
                        default:     result.read_data = 8'h00;
                    endcase
                end
                else
                begin
                    unique case (sel)
                        REG_RBR_THR:
                        begin
                            if (dlab)
                            begin
                                dll_next = item.write_data;
                            end
                            else
                            begin
                                result.tx_valid = 1'b1;
                                result.tx_byte  = item.write_data;
                            end
                        end
                        REG_IER:
                        begin
                            if (dlab)
                            begin
                                dlm_next = item.write_data;
                            end
                            else
                            begin
                                ier_next = item.write_data;
                            end
                        end
                        REG_IIR_FCR: fcr_next = item.write_data;
                        REG_LCR:     lcr_next = item.write_data;
                        REG_MCR:     mcr_next = item.write_data;
                        REG_LSR, REG_MSR: ;  // read-only
                        REG_SCR:     scr_next = item.write_data;
                        default: ;
                    endcase
                end
            end
            OP_RX_CHAR:
            begin
                if (!dr_reg)
                begin
                    rbr_next = item.rx_char;
                    dr_next  = 1'b1;
                end
                else
                begin
                    result.status = ST_RX_FULL;
                end
            end
            OP_IRQ:
            begin
                result.irq_rise = !prev_irq_reg && irq;
                prev_irq_next   = irq;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbr_reg      <= '0;
            dll_reg      <= '0;
            dlm_reg      <= '0;
            ier_reg      <= '0;
            fcr_reg      <= '0;
            lcr_reg      <= '0;
            mcr_reg      <= '0;
            scr_reg      <= '0;
            dr_reg       <= 1'b0;
            prev_irq_reg <= 1'b0;
        end
        else if (fire)
        begin
            rbr_reg      <= rbr_next;
            dll_reg      <= dll_next;
            dlm_reg      <= dlm_next;
            ier_reg      <= ier_next;
            fcr_reg      <= fcr_next;
            lcr_reg      <= lcr_next;
            mcr_reg      <= mcr_next;
            scr_reg      <= scr_next;
            dr_reg       <= dr_next;
            prev_irq_reg <= prev_irq_next;
        end
    end

endmodule

// ===== sv/u16550_out_stage.sv =====
// ----------------------------------------------------------------------------
// u16550_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module u16550_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  u16550_pkg::result_t load_result,
    output logic                take,      // register free or draining
    output logic                out_valid,
    input  logic                out_ready,
    output u16550_pkg::result_t result
);
    import u16550_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign take      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

endmodule

// ===== sv/uart_16550_register_model.sv =====
// ----------------------------------------------------------------------------
// uart_16550_register_model
// Simplified 16550 UART register model: bus reads/writes, receive, irq sample.
// ----------------------------------------------------------------------------
// Path: input register, then result register; the result is registered, and
//   a stalled result register holds the transaction in the input register.
// Throughput: one transaction per cycle while the result side is not stalled;
//   decode plus register update sits between the input and result registers.
// Reset: rst_n async active low; clears both stage valids, config, and UART
//   registers (LSR reads 0x60, data-ready clear).
// ----------------------------------------------------------------------------
module uart_16550_register_model (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [63:0] address,
    input  logic [3:0]  size_bytes,
    input  logic [7:0]  write_data,
    input  logic [7:0]  rx_char,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [7:0]  read_data,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        irq_rise,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import u16550_pkg::*;

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [63:0] base_address_reg;
    logic        stride_is_eight_reg;

    item_t   in_item;
    item_t   exec_item;
    result_t exec_result;
    result_t out_result;
    logic    take;
    logic    fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg    <= '0;
            stride_is_eight_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: base_address_reg    <= cfg_data;
                CFG_STRIDE:       stride_is_eight_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_item.op         = op_t'(op);
    assign in_item.address    = address;
    assign in_item.size_bytes = size_bytes;
    assign in_item.write_data = write_data;
    assign in_item.rx_char    = rx_char;

    // input register; a held transaction executes whenever the result
    // register is free or being drained in the same cycle
    u16550_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .take     (take),
        .fire     (fire),
        .item     (exec_item)
    );

    // decode, UART register state; state commits on fire together with the
    // result load, so the next transaction sees the updated registers
    u16550_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .item            (exec_item),
        .base_address    (base_address_reg),
        .stride_is_eight (stride_is_eight_reg),
        .result          (exec_result)
    );

    u16550_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .load_result (exec_result),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (out_result)
    );

    assign status    = out_result.status;
    assign read_data = out_result.read_data;
    assign tx_valid  = out_result.tx_valid;
    assign tx_byte   = out_result.tx_byte;
    assign irq_rise  = out_result.irq_rise;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 16550 UART register model. A short table of
// directed transactions runs first, then random traffic under several
// base/stride settings and idle mixes. A scoreboard checks every result in
// order against an in-bench register file model or a pinned directed result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u16550_pkg::*;

    // cycles with no transaction on either channel before the run is declared hung
    localparam int unsigned QUIET_LIMIT      = 5000;
    // settle time after the last result
    localparam int unsigned DRAIN_CYCLES     = 8;
    localparam int unsigned RANDOM_PER_PHASE = 250;
    localparam int unsigned NUM_PHASES       = 6;
    localparam int unsigned MAX_REPORTS      = 10;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [63:0] address;
    logic [3:0]  size_bytes;
    logic [7:0]  write_data;
    logic [7:0]  rx_char;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_rise;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    uart_16550_register_model u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .address    (address),
        .size_bytes (size_bytes),
        .write_data (write_data),
        .rx_char    (rx_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_data  (read_data),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .irq_rise   (irq_rise),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Register file model: mirrors config and every UART register
    // ------------------------------------------------------------------------
    logic [63:0] cfg_base;
    logic        cfg_stride8;
    logic [7:0]  rbr_q, dll_q, dlm_q, ier_q, fcr_q, lcr_q, mcr_q, lsr_q, scr_q;
    logic        irq_seen;   // interrupt line level at the last sample

    task automatic regfile_reset();
        cfg_base    = '0;
        cfg_stride8 = 1'b0;
        rbr_q = '0; dll_q = '0; dlm_q = '0; ier_q = '0; fcr_q = '0;
        lcr_q = '0; mcr_q = '0; scr_q = '0;
        lsr_q    = LSR_RESET;
        irq_seen = 1'b0;
    endtask

    // IIR priority: rx data available over THR empty over nothing pending
    function automatic logic [7:0] iir_view();
        if ((ier_q & IER_RX) != 0 && (lsr_q & LSR_DR) != 0)
            return IIR_RDA;
        if ((ier_q & IER_TX) != 0)
            return IIR_THRE;
        return IIR_NONE;
    endfunction

    function automatic result_t regfile_step(item_t it);
        result_t     r;
        logic        size_ok;
        logic [63:0] amask;
        logic [63:0] offset;
        reg_sel_t    sel;
        logic        dlab;
        logic        irq_now;
        r = '0;
        case (it.op)
            OP_READ, OP_WRITE:
            begin
                size_ok = it.size_bytes == 4'd1 || it.size_bytes == 4'd2 ||
                          it.size_bytes == 4'd4 || (it.size_bytes == 4'd8 && cfg_stride8);
                amask   = cfg_stride8 ? 64'd7 : 64'd3;
                // size is checked ahead of alignment
                if (!size_ok)
                    r.status = ST_BAD_SIZE;
                else if ((it.address & amask) != 0)
                    r.status = ST_MISALIGNED;
                else
                begin
                    // offset wraps mod 2^64; only three register bits decode
                    offset = it.address - cfg_base;
                    sel    = reg_sel_t'(cfg_stride8 ? offset[5:3] : offset[4:2]);
                    dlab   = (lcr_q & LCR_DIV_LATCH) != 0;
                    if (it.op == OP_READ)
                    begin
                        case (sel)
                            REG_RBR_THR:
                            begin
                                if (dlab)
                                    r.read_data = dll_q;
                                else
                                begin
                                    r.read_data = rbr_q;
                                    lsr_q       = lsr_q & ~LSR_DR;
                                end
                            end
                            REG_IER:     r.read_data = dlab ? dlm_q : ier_q;
                            REG_IIR_FCR: r.read_data = iir_view();
                            REG_LCR:     r.read_data = lcr_q;
                            REG_MCR:     r.read_data = mcr_q;
                            REG_LSR:     r.read_data = lsr_q;
                            REG_MSR:     r.read_data = '0;
                            default:     r.read_data = scr_q;
                        endcase
                    end
                    else
                    begin
                        case (sel)
                            REG_RBR_THR:
                            begin
                                if (dlab)
                                    dll_q = it.write_data;
                                else
                                begin
                                    r.tx_valid = 1'b1;
                                    r.tx_byte  = it.write_data;
                                end
                            end
                            REG_IER:
                            begin
                                if (dlab)
                                    dlm_q = it.write_data;
                                else
                                    ier_q = it.write_data;
                            end
                            REG_IIR_FCR: fcr_q = it.write_data;
                            REG_LCR:     lcr_q = it.write_data;
                            REG_MCR:     mcr_q = it.write_data;
                            REG_LSR, REG_MSR: ;
                            default:     scr_q = it.write_data;
                        endcase
                    end
                end
            end
            OP_RX_CHAR:
            begin
                if ((lsr_q & LSR_DR) == 0)
                begin
                    rbr_q = it.rx_char;
                    lsr_q = lsr_q | LSR_DR;
                end
                else
                    r.status = ST_RX_FULL;
            end
            default:
            begin
                irq_now    = (iir_view() & IIR_NONE) == 0;
                r.irq_rise = !irq_seen && irq_now;
                irq_seen   = irq_now;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: prediction on input transaction, in-order compare on output
    // ------------------------------------------------------------------------
    result_t     due_results[$];
    logic        in_accepted;     // input transaction seen at the last rising edge
    int unsigned quiet_cycles;
    int unsigned failures;
    logic        row_pinned;      // current directed row carries its own result
    result_t     row_result;
    item_t       seen_item;
    result_t     predicted;
    result_t     got;
    result_t     want;

    always @(posedge clk)
    begin
        in_accepted <= in_valid && in_ready;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;

        if (in_valid && in_ready)
        begin
            seen_item.op         = op_t'(op);
            seen_item.address    = address;
            seen_item.size_bytes = size_bytes;
            seen_item.write_data = write_data;
            seen_item.rx_char    = rx_char;
            // model always steps so its state tracks pinned rows too
            predicted = regfile_step(seen_item);
            due_results.push_back(row_pinned ? row_result : predicted);
        end

        if (out_valid && out_ready)
        begin
            got.status    = status_t'(status);
            got.read_data = read_data;
            got.tx_valid  = tx_valid;
            got.tx_byte   = tx_byte;
            got.irq_rise  = irq_rise;
            if (due_results.size() == 0)
            begin
                if (failures < MAX_REPORTS)
                    $display("unexpected result: st=%0d rd=%02h tx=%0b/%02h rise=%0b",
                             got.status, got.read_data, got.tx_valid, got.tx_byte,
                             got.irq_rise);
                failures++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got.status !== want.status || got.read_data !== want.read_data ||
                    got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                    got.irq_rise !== want.irq_rise)
                begin
                    if (failures < MAX_REPORTS)
                        $display({"mismatch: exp st=%0d rd=%02h tx=%0b/%02h rise=%0b,",
                                  " got st=%0d rd=%02h tx=%0b/%02h rise=%0b"},
                                 want.status, want.read_data, want.tx_valid, want.tx_byte,
                                 want.irq_rise, got.status, got.read_data, got.tx_valid,
                                 got.tx_byte, got.irq_rise);
                    failures++;
                end
            end
        end
    end

    // hang detector
    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[uart_16550_register_model] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output backpressure: random stall, percent set per phase
    // ------------------------------------------------------------------------
    int unsigned gap_pct;     // sender idle, percent of cycles
    int unsigned stall_pct;   // receiver stall, percent of cycles

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    typedef struct {
        item_t   it;
        logic    pinned;
        result_t res;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic result_t outcome(status_t st, logic [7:0] rd, logic txv,
                                        logic [7:0] txb, logic rise);
        result_t r;
        r.status    = st;
        r.read_data = rd;
        r.tx_valid  = txv;
        r.tx_byte   = txb;
        r.irq_rise  = rise;
        return r;
    endfunction

    task automatic add_row(input op_t o, input logic [63:0] a, input logic [3:0] s,
                           input logic [7:0] wd, input logic [7:0] rx,
                           input logic pinned, input result_t r);
        dir_row_t row;
        row.it.op         = o;
        row.it.address    = a;
        row.it.size_bytes = s;
        row.it.write_data = wd;
        row.it.rx_char    = rx;
        row.pinned        = pinned;
        row.res           = r;
        dir_rows.push_back(row);
    endtask

    // Random access: mostly well-formed hits on a register of the current
    // window, RBR favored so the receive path keeps cycling; a slice is
    // misaligned, bad-sized, or anywhere in the 64-bit space.
    function automatic item_t gen_item();
        item_t       it;
        int unsigned pick;
        int unsigned shift;
        logic [63:0] amask;
        logic [2:0]  target;
        pick = $urandom_range(99);
        if (pick < 35)
            it.op = OP_READ;
        else if (pick < 70)
            it.op = OP_WRITE;
        else if (pick < 85)
            it.op = OP_RX_CHAR;
        else
            it.op = OP_IRQ;

        shift  = cfg_stride8 ? 3 : 2;
        amask  = cfg_stride8 ? 64'd7 : 64'd3;
        target = ($urandom_range(99) < 30) ? REG_RBR_THR : 3'($urandom_range(7));
        pick   = $urandom_range(99);
        if (pick < 80)
            it.address = (cfg_base + (64'(target) << shift)) & ~amask;
        else if (pick < 90)
            it.address = ((cfg_base + (64'(target) << shift)) & ~amask) |
                         64'($urandom_range(int'(amask), 1));
        else
            it.address = {$urandom, $urandom};

        if ($urandom_range(99) < 90)
            it.size_bytes = 4'd1 << $urandom_range(cfg_stride8 ? 3 : 2);
        else
            it.size_bytes = 4'($urandom_range(8));

        it.write_data = 8'($urandom_range(255));
        // keep DLAB mostly clear so RBR/THR/IER stay reachable
        if (target == REG_LCR && $urandom_range(99) < 70)
            it.write_data[7] = 1'b0;
        it.rx_char = 8'($urandom_range(255));
        return it;
    endfunction

    // Present one input transaction; returns at the falling edge after it is taken.
    task automatic send_item(input item_t it, input logic pinned, input result_t r);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= it.op;
        address    <= it.address;
        size_bytes <= it.size_bytes;
        write_data <= it.write_data;
        rx_char    <= it.rx_char;
        row_pinned <= pinned;
        row_result <= r;
        @(negedge clk);
        while (!in_accepted)
            @(negedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
    endtask

    // Config writes only with the pipe empty; mirror follows the DUT.
    task automatic load_config(input logic [63:0] base, input logic stride8);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_ADDRESS;
        cfg_data  <= base;
        @(negedge clk);
        cfg_index <= CFG_STRIDE;
        cfg_data  <= {63'd0, stride8};
        @(negedge clk);
        cfg_we      <= 1'b0;
        cfg_base    = base;
        cfg_stride8 = stride8;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_READ;
        address     = '0;
        size_bytes  = '0;
        write_data  = '0;
        rx_char     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_BASE_ADDRESS;
        cfg_data    = '0;
        row_pinned  = 1'b0;
        row_result  = '0;
        in_accepted = 1'b0;
        failures    = 0;
        gap_pct     = 0;
        stall_pct   = 0;
        regfile_reset();

        // Directed table, reset config: base 0, registers 4 bytes apart.
        // Reset values, size and alignment errors, THR emit, the first receive and the
        // receive full case carry their result inline; the rest go through the model.
        add_row(OP_READ,  64'h14, 4'd1, 8'h00, 8'h00, 1'b1,
                outcome(ST_OK, LSR_RESET, 1'b0, '0, 1'b0));
        add_row(OP_READ,  64'h08, 4'd2, 8'h00, 8'h00, 1'b1,
                outcome(ST_OK, IIR_NONE, 1'b0, '0, 1'b0));
        add_row(OP_READ,  64'h18, 4'd4, 8'h00, 8'h00, 1'b1,
                outcome(ST_OK, 8'h00, 1'b0, '0, 1'b0));
        add_row(OP_READ,  64'h00, 4'd0, 8'h00, 8'h00, 1'b1,
                outcome(ST_BAD_SIZE, '0, 1'b0, '0, 1'b0));
        // eight-byte access only legal with the eight-byte stride
        add_row(OP_READ,  64'h00, 4'd8, 8'h00, 8'h00, 1'b1,
                outcome(ST_BAD_SIZE, '0, 1'b0, '0, 1'b0));
        add_row(OP_WRITE, 64'h00, 4'd3, 8'hFF, 8'h00, 1'b1,
                outcome(ST_BAD_SIZE, '0, 1'b0, '0, 1'b0));
        add_row(OP_READ,  64'h01, 4'd1, 8'h00, 8'h00, 1'b1,
                outcome(ST_MISALIGNED, '0, 1'b0, '0, 1'b0));
        add_row(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFE, 4'd4, 8'hFF, 8'hFF, 1'b1,
                outcome(ST_MISALIGNED, '0, 1'b0, '0, 1'b0));
        add_row(OP_WRITE, 64'h00, 4'd1, 8'hFF, 8'h00, 1'b1,
                outcome(ST_OK, '0, 1'b1, 8'hFF, 1'b0));
        // receive ignores address and size: no error even with junk there
        add_row(OP_RX_CHAR, 64'h03, 4'd0, 8'h00, 8'hFF, 1'b1,
                outcome(ST_OK, '0, 1'b0, '0, 1'b0));
        add_row(OP_RX_CHAR, 64'h00, 4'd1, 8'h00, 8'h00, 1'b1,
                outcome(ST_RX_FULL, '0, 1'b0, '0, 1'b0));
        add_row(OP_READ,  64'h14, 4'd1, 8'h00, 8'h00, 1'b0, '0);   // LSR with data ready
        add_row(OP_WRITE, 64'h04, 4'd1, 8'h01, 8'h00, 1'b0, '0);   // IER rx enable
        add_row(OP_IRQ,   64'h07, 4'd0, 8'hFF, 8'hFF, 1'b0, '0);   // irq goes high
        add_row(OP_READ,  64'h08, 4'd1, 8'h00, 8'h00, 1'b0, '0);   // IIR rx data
        add_row(OP_READ,  64'h20, 4'd4, 8'h00, 8'h00, 1'b0, '0);   // RBR via alias
        // negative offset wraps onto IER
        add_row(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFE4, 4'd2, 8'h02, 8'h00, 1'b0, '0);
        add_row(OP_IRQ,   64'h00, 4'd1, 8'h00, 8'h00, 1'b0, '0);
        add_row(OP_WRITE, 64'h0C, 4'd1, 8'h83, 8'h00, 1'b0, '0);   // LCR, DLAB set
        add_row(OP_WRITE, 64'h00, 4'd1, 8'h34, 8'h00, 1'b0, '0);   // DLL, no emit
        add_row(OP_WRITE, 64'h04, 4'd1, 8'h12, 8'h00, 1'b0, '0);   // DLM
        add_row(OP_READ,  64'h00, 4'd1, 8'h00, 8'h00, 1'b0, '0);
        add_row(OP_READ,  64'h04, 4'd1, 8'h00, 8'h00, 1'b0, '0);
        add_row(OP_WRITE, 64'h1C, 4'd1, 8'hA5, 8'h00, 1'b0, '0);   // SCR
        add_row(OP_READ,  64'h1C, 4'd1, 8'h00, 8'h00, 1'b0, '0);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].res);

        // Random phases: each sets a new window and idle mix; extremes of
        // the base address and both strides are covered.
        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: load_config(64'd0, 1'b0);
                1: load_config(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
                2: load_config({$urandom, $urandom}, 1'b0);
                3: load_config({$urandom, $urandom} & ~64'd7, 1'b1);
                4: load_config(64'h8000_0000_0000_0000, 1'b0);
                default: load_config({$urandom, $urandom}, 1'($urandom_range(1)));
            endcase
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 55; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 55; end
                3: begin gap_pct = 28; stall_pct = 28; end
                4: begin gap_pct = 0;  stall_pct = 0;  end
                default: begin gap_pct = 28; stall_pct = 28; end
            endcase
            for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                // mid-phase hold-off: let the result side run dry
                if (i == RANDOM_PER_PHASE / 2)
                    drain();
                send_item(gen_item(), 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0 && due_results.size() == 0)
            $display("[uart_16550_register_model] OK");
        else
            $display("[uart_16550_register_model] ERROR");
        $finish;
    end

endmodule
